FILE: sv/tkmh_pkg.sv
// Shared types and constants for the top-K min-heap unit.
// No dependencies; the datapath, controller and top level use this package.
`timescale 1ns / 1ps

package tkmh_pkg;

    localparam int HEAP_SIZE = 16;
    localparam int IDX_W     = (HEAP_SIZE > 1) ? $clog2(HEAP_SIZE) : 1;
    localparam int KEY_W     = 48;
    localparam int CNT_W     = 32;

    localparam logic OP_OFFER = 1'b0;
    localparam logic OP_DUMP  = 1'b1;

    typedef logic [IDX_W-1:0] idx_t;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [CNT_W-1:0] cnt;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_item;   // capture the input transaction
        logic rd_root;     // read slot 0 on port A
        logic rd_dump;     // read the dump slot on port A
        logic wr_child;    // move the smaller child up into the current node
        logic wr_item;     // place the held item at the current node
        logic ld_offer;    // load an offer result into the output register
        logic offer_acc;   // accepted flag for ld_offer
        logic ld_dump;     // load the dump read data into the output register
        logic idx_inc;     // advance to the next dump slot
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic op;          // operation of the held item
        logic beats_root;  // held count is strictly above the root count
        logic has_child;   // current node has a left child
        logic swap;        // a child is strictly smaller than the held item
        logic dump_last;   // dump index is at the final slot
        logic out_valid;   // output register holds an untaken result
    } status_t;

endpackage

FILE: sv/tkmh_ram.sv
// Generic RAM: one write port, two read ports, registered read data.
// No dependencies.
`timescale 1ns / 1ps

module tkmh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                       aclk,
    input  logic                                       we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                           wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_a,
    output logic [WIDTH-1:0]                           rdata_a,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_b,
    output logic [WIDTH-1:0]                           rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

FILE: sv/tkmh_dp.sv
// Datapath of the top-K min-heap unit: heap RAM, slot valid bits, held item,
// node and dump indexes, compare logic and the output register. Uses tkmh_pkg, tkmh_ram.
`timescale 1ns / 1ps

module tkmh_dp (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  tkmh_pkg::cmd_t             cmd,
    output tkmh_pkg::status_t          status,
    input  logic                       in_op,
    input  logic [tkmh_pkg::KEY_W-1:0] in_key,
    input  logic [tkmh_pkg::CNT_W-1:0] in_cnt,
    input  logic                       out_ready,
    output logic                       out_valid,
    output logic                       out_acc,
    output logic [tkmh_pkg::KEY_W-1:0] out_key,
    output logic [tkmh_pkg::CNT_W-1:0] out_cnt,
    output logic                       out_last
);

    import tkmh_pkg::*;

    logic               op_reg;
    entry_t             item_reg;
    idx_t               pos_reg, pos_next;
    idx_t               idx_reg, idx_next;
    logic [HEAP_SIZE-1:0] vld_reg;
    logic               vld_a_reg, vld_b_reg;
    logic               r_ok_reg;
    logic               out_valid_reg, out_valid_next;
    logic               out_acc_reg;
    entry_t             out_entry_reg;
    logic               out_last_reg;

    logic [IDX_W:0]     child_l, child_r;
    idx_t               raddr_a, raddr_b, waddr;
    entry_t             ram_a, ram_b, rd_a, rd_b, wdata, best_entry;
    idx_t               best_idx;
    logic               we, l_less, r_less;

    // Children of node i sit at 2i+1 and 2i+2 (zero-based slots).
    assign child_l = {pos_reg, 1'b1};
    assign child_r = child_l + (IDX_W+1)'(1);

    always_comb begin
        raddr_a = child_l[IDX_W-1:0];
        if (cmd.rd_root) begin
            raddr_a = '0;
        end else if (cmd.rd_dump) begin
            raddr_a = idx_reg;
        end
    end
    assign raddr_b = child_r[IDX_W-1:0];

    assign we    = cmd.wr_child | cmd.wr_item;
    assign waddr = pos_reg;
    assign wdata = cmd.wr_child ? best_entry : item_reg;

    tkmh_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (HEAP_SIZE)
    ) u_ram (
        .aclk    (aclk),
        .we      (we),
        .waddr   (waddr),
        .wdata   (wdata),
        .raddr_a (raddr_a),
        .rdata_a (ram_a),
        .raddr_b (raddr_b),
        .rdata_b (ram_b)
    );

    // Slots never written since reset read as zero key and zero count.
    assign rd_a = vld_a_reg ? ram_a : '0;
    assign rd_b = vld_b_reg ? ram_b : '0;

    // Left child is checked first; the right one must beat the current best.
    always_comb begin
        l_less     = rd_a.cnt < item_reg.cnt;
        best_entry = l_less ? rd_a : item_reg;
        best_idx   = pos_reg;
        if (l_less) begin
            best_idx = child_l[IDX_W-1:0];
        end
        r_less = r_ok_reg && (rd_b.cnt < best_entry.cnt);
        if (r_less) begin
            best_entry = rd_b;
            best_idx   = child_r[IDX_W-1:0];
        end
    end

    always_comb begin
        pos_next = pos_reg;
        if (cmd.load_item) begin
            pos_next = '0;
        end else if (cmd.wr_child) begin
            pos_next = best_idx;
        end
    end

    always_comb begin
        idx_next = idx_reg;
        if (cmd.load_item) begin
            idx_next = '0;
        end else if (cmd.idx_inc) begin
            idx_next = idx_reg + IDX_W'(1);
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd.ld_offer || cmd.ld_dump) begin
            out_valid_next = 1'b1;
        end else if (out_valid_reg && out_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
            pos_reg       <= '0;
            idx_reg       <= '0;
        end else begin
            if (we) begin
                vld_reg[waddr] <= 1'b1;
            end
            out_valid_reg <= out_valid_next;
            pos_reg       <= pos_next;
            idx_reg       <= idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        vld_a_reg <= vld_reg[raddr_a];
        vld_b_reg <= vld_reg[raddr_b];
        r_ok_reg  <= child_r < (IDX_W+1)'(HEAP_SIZE);
        if (cmd.load_item) begin
            op_reg       <= in_op;
            item_reg.key <= in_key;
            item_reg.cnt <= in_cnt;
        end
        if (cmd.ld_offer) begin
            out_acc_reg   <= cmd.offer_acc;
            out_entry_reg <= '0;
            out_last_reg  <= 1'b1;
        end else if (cmd.ld_dump) begin
            out_acc_reg   <= 1'b0;
            out_entry_reg <= rd_a;
            out_last_reg  <= (idx_reg == IDX_W'(HEAP_SIZE - 1));
        end
    end

    assign status.op         = op_reg;
    assign status.beats_root = item_reg.cnt > rd_a.cnt;
    assign status.has_child  = child_l < (IDX_W+1)'(HEAP_SIZE);
    assign status.swap       = l_less | r_less;
    assign status.dump_last  = (idx_reg == IDX_W'(HEAP_SIZE - 1));
    assign status.out_valid  = out_valid_reg;

    assign out_valid = out_valid_reg;
    assign out_acc   = out_acc_reg;
    assign out_key   = out_entry_reg.key;
    assign out_cnt   = out_entry_reg.cnt;
    assign out_last  = out_last_reg;

    // A child moved up always makes the walk go one level deeper.
    a_pos_deeper: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.wr_child |=> pos_reg > $past(pos_reg))
        else $error("sift-down did not move to a deeper node");

    // The heap is never written while a result waits in the output register.
    a_no_wr_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        we |-> !out_valid_reg)
        else $error("heap written while a result is pending");

    // An offer result carries zero entry fields and the last flag.
    a_offer_out: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.ld_offer |=> out_valid_reg && out_last_reg && (out_entry_reg == '0))
        else $error("malformed offer result");

    // A dump result is flagged last exactly on the final slot.
    a_dump_last: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.ld_dump |=> out_last_reg == ($past(idx_reg) == IDX_W'(HEAP_SIZE - 1)))
        else $error("dump last flag on the wrong slot");

endmodule

FILE: sv/tkmh_ctrl.sv
// Controller of the top-K min-heap unit: sequences root check, sift-down
// and dump reads. Uses tkmh_pkg; talks to tkmh_dp through cmd_t and status_t.
`timescale 1ns / 1ps

module tkmh_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                out_ready,
    input  tkmh_pkg::status_t   status,
    output tkmh_pkg::cmd_t      cmd
);

    import tkmh_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE     = 8'b0000_0001,
        S_ROOT_RD  = 8'b0000_0010,
        S_ROOT_CMP = 8'b0000_0100,
        S_SIFT_RD  = 8'b0000_1000,
        S_SIFT_CMP = 8'b0001_0000,
        S_DUMP_RD  = 8'b0010_0000,
        S_DUMP_LD  = 8'b0100_0000,
        S_OUT      = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE: begin
                if (in_valid) begin
                    cmd.load_item = 1'b1;
                    state_next    = S_ROOT_RD;
                end
            end
            S_ROOT_RD: begin
                if (status.op == OP_DUMP) begin
                    cmd.rd_dump = 1'b1;
                    state_next  = S_DUMP_LD;
                end else begin
                    cmd.rd_root = 1'b1;
                    state_next  = S_ROOT_CMP;
                end
            end
            S_ROOT_CMP: begin
                if (status.beats_root) begin
                    state_next = S_SIFT_RD;
                end else begin
                    cmd.ld_offer  = 1'b1;
                    cmd.offer_acc = 1'b0;
                    state_next    = S_OUT;
                end
            end
            S_SIFT_RD: begin
                if (status.has_child) begin
                    state_next = S_SIFT_CMP;
                end else begin
                    cmd.wr_item   = 1'b1;
                    cmd.ld_offer  = 1'b1;
                    cmd.offer_acc = 1'b1;
                    state_next    = S_OUT;
                end
            end
            S_SIFT_CMP: begin
                if (status.swap) begin
                    cmd.wr_child = 1'b1;
                    state_next   = S_SIFT_RD;
                end else begin
                    cmd.wr_item   = 1'b1;
                    cmd.ld_offer  = 1'b1;
                    cmd.offer_acc = 1'b1;
                    state_next    = S_OUT;
                end
            end
            S_DUMP_RD: begin
                cmd.rd_dump = 1'b1;
                state_next  = S_DUMP_LD;
            end
            S_DUMP_LD: begin
                cmd.ld_dump = 1'b1;
                state_next  = S_OUT;
            end
            S_OUT: begin
                if (status.out_valid && out_ready) begin
                    if (status.op == OP_DUMP && !status.dump_last) begin
                        cmd.idx_inc = 1'b1;
                        state_next  = S_DUMP_RD;
                    end else begin
                        state_next = S_IDLE;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Input is taken only when no result of the previous transaction is pending.
    a_idle_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid && in_ready) |-> !status.out_valid)
        else $error("input taken with a result still pending");

    // Leaving the output state means the pending result was taken.
    a_out_taken: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_OUT && state_next != S_OUT) |=> !status.out_valid)
        else $error("result dropped or not cleared");

endmodule

FILE: sv/top_k_min_heap_unit.sv
// Top level of the top-K min-heap unit: stream ports, controller and datapath.
// Uses tkmh_pkg, tkmh_ctrl, tkmh_dp (which holds the tkmh_ram heap store).
//
//  channel | ports                      | tdata (low bit up)                 | tuser / tlast
//  --------+----------------------------+------------------------------------+-------------------
//  input   | s_tvalid s_tready s_tdata  | offer_key[47:0] offer_count[79:48] | tuser: operation
//  result  | m_tvalid m_tready m_tdata  | accepted[0] entry_key[48:1]        | tlast: last_entry
//          |                            | entry_count[80:49], zero pad       |
//
// One transaction at a time. A rejected offer reads and compares the root, then waits
// for the output; an accepted one also walks the sift-down, with a read state and a
// compare state on each heap level, both children read on the heap RAM's two read ports.
// A dump gives HEAP_SIZE results, each through read, load and output states; low m_tready stalls it.
// After reset every slot reads as zero through per-slot valid bits; no clearing pass.
// A stalled result holds in the output register; s_tready is low until it is taken.
`timescale 1ns / 1ps

module top_k_min_heap_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [79:0] s_tdata,   // offer_key[47:0], offer_count[79:48]
    input  logic        s_tuser,   // operation
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [87:0] m_tdata,   // accepted[0], entry_key[48:1], entry_count[80:49]
    output logic        m_tlast
);

    import tkmh_pkg::*;

    cmd_t             cmd;
    status_t          status;
    logic             out_acc;
    logic [KEY_W-1:0] out_key;
    logic [CNT_W-1:0] out_cnt;

    tkmh_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .out_ready (m_tready),
        .status    (status),
        .cmd       (cmd)
    );

    tkmh_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .in_op     (s_tuser),
        .in_key    (s_tdata[KEY_W-1:0]),
        .in_cnt    (s_tdata[KEY_W+CNT_W-1:KEY_W]),
        .out_ready (m_tready),
        .out_valid (m_tvalid),
        .out_acc   (out_acc),
        .out_key   (out_key),
        .out_cnt   (out_cnt),
        .out_last  (m_tlast)
    );

    assign m_tdata = {7'd0, out_cnt, out_key, out_acc};

endmodule
